[rtl/core/cct_pkg.sv]
`default_nettype none

package cct_pkg;

	// counter sample width actually used (16 to 32)
	localparam int COUNT_BITS = 32;

	// field widths
	localparam int CYC_W   = 32;
	localparam int TOTAL_W = 64;
	localparam int SEC_W   = 45;
	localparam int FRAC_W  = 10;
	localparam int MHZ_W   = 10;
	localparam int WRAP_W  = 32;

	// divider widths: largest divisor is 1023 * 10^6, below 2^30
	localparam int DEN_W   = 30;
	localparam int SCALE_W = 20;
	localparam int CNT_W   = 7;
	localparam int SEC_US_W = SEC_W + SCALE_W;
	localparam int MS_US_W  = FRAC_W + SCALE_W;

	// stream data widths, padded to whole bytes
	localparam int IN_DATA_W  = CYC_W;
	localparam int OUT_BITS   = 2 * TOTAL_W + SEC_W + 2 * FRAC_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// output field offsets
	localparam int SEC_LSB   = TOTAL_W;
	localparam int MS_LSB    = SEC_LSB + SEC_W;
	localparam int US_LSB    = MS_LSB + FRAC_W;
	localparam int MICRO_LSB = US_LSB + FRAC_W;

	localparam logic [MHZ_W-1:0]   CPU_MHZ_RESET = MHZ_W'(168);
	localparam logic [SCALE_W-1:0] PER_SECOND    = SCALE_W'(1000000);
	localparam logic [SCALE_W-1:0] PER_MILLI     = SCALE_W'(1000);
	localparam logic [CNT_W-1:0]   SEC_STEPS     = CNT_W'(TOTAL_W);
	localparam logic [CNT_W-1:0]   FRAC_STEPS    = CNT_W'(FRAC_W);

endpackage

`default_nettype wire

[rtl/core/cycle_count_timebase.sv]
`default_nettype none

// cycle_count_timebase: extends samples of a free-running cycle counter to a
// 64-bit count and splits it into seconds, milliseconds and microseconds.
// input beat (s_axis): tdata carries the counter sample, tuser the restart
// flag; restart clears the wrap count and takes the sample as baseline.
// output beat (m_axis): total cycles, whole seconds, ms within the second,
// us within the ms, and total microseconds, packed in tdata.
// cpu_mhz is written through cfg_wr_en / cfg_wr_data by the user, only
// while idle; the block itself does not enforce this. 0 acts as 1.
// an accepted input beat is worked by one shared restoring divider
// retiring one quotient bit per cycle: 64 steps for seconds, 10 for
// milliseconds, 10 for microseconds, plus six load, multiply, add and
// output steps. one item is in work at a time; a new input beat is
// taken as soon as the sequencer is idle again, even while the previous
// result still waits in the output register.
// if the receiver stalls, the result holds in the output register and the
// sequencer waits at its last step until the register frees up.
// reset: wrap count and last sample clear to zero, cpu_mhz returns to 168,
// no output beat is pending.

module cycle_count_timebase (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [cct_pkg::MHZ_W-1:0]       cfg_wr_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// cycle_count[31:0]
	input  wire logic [cct_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// restart
	input  wire logic                            s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// total_cycles[63:0], seconds[108:64], milliseconds[118:109],
	// microseconds[128:119], total_micros[192:129], zero pad[199:193]
	output logic [cct_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
	import cct_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_S,
		ST_LD_MS,
		ST_DIV_MS,
		ST_LD_US,
		ST_DIV_US,
		ST_MUL,
		ST_SUM,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [MHZ_W-1:0]        cpu_mhz_q;
	logic [MHZ_W-1:0]        mhz_q;
	logic [COUNT_BITS-1:0]   last_q;
	logic [WRAP_W-1:0]       wrap_q;

	logic [TOTAL_W-1:0]      total_q;
	logic [TOTAL_W-1:0]      num_q;
	logic [DEN_W-1:0]        part_q;
	logic [DEN_W-1:0]        den_q;
	logic [SEC_W-1:0]        secs_q;
	logic [FRAC_W-1:0]       ms_q;
	logic [FRAC_W-1:0]       us_q;
	logic [TOTAL_W-1:0]      micros_q;

	logic                    in_beat;
	logic                    out_free;
	logic                    out_load;
	logic                    div_active;
	logic [COUNT_BITS-1:0]   now;
	logic [WRAP_W-1:0]       wrap_next;
	logic [TOTAL_W-1:0]      total_next;
	logic [DEN_W:0]          trial;
	logic [DEN_W:0]          diff;
	logic                    qbit;
	logic [DEN_W-1:0]        part_next;
	logic [SEC_US_W-1:0]     sec_us;
	logic [MS_US_W-1:0]      ms_us;

	assign in_beat    = s_axis_tvalid && s_axis_tready;
	assign out_free   = !m_axis_tvalid || m_axis_tready;
	assign out_load   = (state_q == ST_DONE) && out_free;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign div_active = (state_q == ST_DIV_S) || (state_q == ST_DIV_MS) ||
		(state_q == ST_DIV_US);

	// wrap extension of the incoming sample
	assign now = s_axis_tdata[COUNT_BITS-1:0];
	always_comb begin
		if (s_axis_tuser) begin
			wrap_next = '0;
		end else if (now < last_q) begin
			wrap_next = wrap_q + WRAP_W'(1);
		end else begin
			wrap_next = wrap_q;
		end
	end
	assign total_next = (TOTAL_W'(wrap_next) << COUNT_BITS) | TOTAL_W'(now);

	// shared restoring divider step, one quotient bit per cycle
	assign trial     = {part_q, num_q[TOTAL_W-1]};
	assign diff      = trial - {1'b0, den_q};
	assign qbit      = (trial >= {1'b0, den_q});
	assign part_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	// recombination products for total microseconds
	assign sec_us = SEC_US_W'(secs_q) * SEC_US_W'(PER_SECOND);
	assign ms_us  = MS_US_W'(ms_q) * MS_US_W'(PER_MILLI);

	// sequencer, config register, timebase state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			cpu_mhz_q     <= CPU_MHZ_RESET;
			last_q        <= '0;
			wrap_q        <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cpu_mhz_q <= cfg_wr_data;
			end
			// valid rises with a new result, drops once the beat is taken
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						wrap_q  <= wrap_next;
						last_q  <= now;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q   <= SEC_STEPS;
					state_q <= ST_DIV_S;
				end
				ST_DIV_S: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_LD_MS;
					end
				end
				ST_LD_MS: begin
					cnt_q   <= FRAC_STEPS;
					state_q <= ST_DIV_MS;
				end
				ST_DIV_MS: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_LD_US;
					end
				end
				ST_LD_US: begin
					cnt_q   <= FRAC_STEPS;
					state_q <= ST_DIV_US;
				end
				ST_DIV_US: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					total_q <= total_next;
					mhz_q   <= (cpu_mhz_q == '0) ? MHZ_W'(1) : cpu_mhz_q;
				end
			end
			ST_PREP: begin
				num_q  <= total_q;
				part_q <= '0;
				den_q  <= DEN_W'(DEN_W'(mhz_q) * DEN_W'(PER_SECOND));
			end
			ST_DIV_S, ST_DIV_MS, ST_DIV_US: begin
				num_q  <= {num_q[TOTAL_W-2:0], qbit};
				part_q <= part_next;
			end
			ST_LD_MS: begin
				// quotient below 2^10, so pre-shift the remainder by 10
				secs_q <= num_q[SEC_W-1:0];
				num_q  <= {part_q[FRAC_W-1:0], (TOTAL_W - FRAC_W)'(0)};
				part_q <= part_q >> FRAC_W;
				den_q  <= DEN_W'(DEN_W'(mhz_q) * DEN_W'(PER_MILLI));
			end
			ST_LD_US: begin
				ms_q   <= num_q[FRAC_W-1:0];
				num_q  <= {part_q[FRAC_W-1:0], (TOTAL_W - FRAC_W)'(0)};
				part_q <= part_q >> FRAC_W;
				den_q  <= DEN_W'(mhz_q);
			end
			ST_MUL: begin
				us_q     <= num_q[FRAC_W-1:0];
				micros_q <= sec_us[TOTAL_W-1:0];
			end
			ST_SUM: begin
				micros_q <= micros_q + TOTAL_W'(ms_us) + TOTAL_W'(us_q);
			end
			ST_DONE: begin
				if (out_free) begin
					m_axis_tdata <= {(OUT_DATA_W - OUT_BITS)'(0), micros_q, us_q, ms_q,
						secs_q, total_q};
				end
			end
			default: begin
			end
		endcase
	end

	// accepted beat always starts the sequence
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_PREP))
		else $error("accepted beat did not start the sequencer");

	// restart clears the wrap count
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_axis_tuser) |=> (wrap_q == '0))
		else $error("restart did not clear the wrap count");

	// partial remainder stays below the divisor while dividing
	a_part: assert property (@(posedge clk) disable iff (!arst_n)
		div_active |-> (part_q < den_q))
		else $error("divider partial remainder out of range");

	// step counter never runs dry inside a division
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		div_active |-> (cnt_q != '0))
		else $error("divider step counter empty during division");

	// sub-second fields stay below one thousand
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			((m_axis_tdata[MS_LSB +: FRAC_W] < FRAC_W'(1000)) &&
			(m_axis_tdata[US_LSB +: FRAC_W] < FRAC_W'(1000))))
		else $error("millisecond or microsecond field out of range");

endmodule

`default_nettype wire

[verif/cycle_count_timebase_tb.sv]
module cycle_count_timebase_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cct_pkg::*;

	// one output beat, unpacked
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [SEC_W-1:0]   secs;
		logic [FRAC_W-1:0]  msec;
		logic [FRAC_W-1:0]  usec;
		logic [TOTAL_W-1:0] micros;
	} stamp_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_CHECKED, ROW_TYPED} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [MHZ_W-1:0]   mhz;
		logic [CYC_W-1:0]   sample;
		logic               restart;
		stamp_t             want;
	} stim_row_t;

	localparam int DIR_ROWS_N = 27;
	localparam int RANDOM_ITEMS = 1425;
	localparam int DRAIN_CYCLES = 100;

	// directed rows: reset clock first, then clock of zero, top of range and 1000
	localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
		'{ROW_TYPED,   10'd0, 32'd0,          1'b0, '{64'd0, 45'd0, 10'd0, 10'd0, 64'd0}},
		'{ROW_TYPED,   10'd0, 32'd0,          1'b0, '{64'd0, 45'd0, 10'd0, 10'd0, 64'd0}},
		'{ROW_TYPED,   10'd0, 32'd168,        1'b0, '{64'd168, 45'd0, 10'd0, 10'd1, 64'd1}},
		'{ROW_TYPED,   10'd0, 32'd168000,     1'b0,
			'{64'd168000, 45'd0, 10'd1, 10'd0, 64'd1000}},
		'{ROW_TYPED,   10'd0, 32'd168000000,  1'b0,
			'{64'd168000000, 45'd1, 10'd0, 10'd0, 64'd1000000}},
		'{ROW_CHECKED, 10'd0, 32'hFFFF_FFFF,  1'b0, '0},
		'{ROW_CHECKED, 10'd0, 32'h0000_0000,  1'b0, '0},
		'{ROW_CHECKED, 10'd0, 32'd5,          1'b0, '0},
		'{ROW_CHECKED, 10'd0, 32'd3,          1'b0, '0},
		'{ROW_TYPED,   10'd0, 32'd3,          1'b1, '{64'd3, 45'd0, 10'd0, 10'd0, 64'd0}},
		'{ROW_CHECKED, 10'd0, 32'h8000_0000,  1'b0, '0},
		'{ROW_CHECKED, 10'd0, 32'h7FFF_FFFF,  1'b0, '0},
		'{ROW_CHECKED, 10'd0, 32'hFFFF_FFFF,  1'b1, '0},
		'{ROW_CHECKED, 10'd0, 32'hAAAA_AAAA,  1'b0, '0},
		'{ROW_CHECKED, 10'd0, 32'h5555_5555,  1'b0, '0},
		'{ROW_TYPED,   10'd0, 32'd0,          1'b1, '{64'd0, 45'd0, 10'd0, 10'd0, 64'd0}},
		'{ROW_CFG,     10'd0, 32'd0,          1'b0, '0},
		'{ROW_TYPED,   10'd0, 32'd12345,      1'b1,
			'{64'd12345, 45'd0, 10'd12, 10'd345, 64'd12345}},
		'{ROW_TYPED,   10'd0, 32'd1000000,    1'b0,
			'{64'd1000000, 45'd1, 10'd0, 10'd0, 64'd1000000}},
		'{ROW_CHECKED, 10'd0, 32'd2500,       1'b0, '0},
		'{ROW_CFG,     10'd1023, 32'd0,       1'b0, '0},
		'{ROW_CHECKED, 10'd0, 32'hFFFF_FFFF,  1'b0, '0},
		'{ROW_CHECKED, 10'd0, 32'd1,          1'b0, '0},
		'{ROW_CFG,     10'd1000, 32'd0,       1'b0, '0},
		'{ROW_TYPED,   10'd0, 32'd1000,       1'b1, '{64'd1000, 45'd0, 10'd0, 10'd1, 64'd1}},
		'{ROW_CHECKED, 10'd0, 32'hFFFF_FFFF,  1'b0, '0},
		'{ROW_CHECKED, 10'd0, 32'd77,         1'b0, '0}
	};

	localparam logic [MHZ_W-1:0] EXTREME_MHZ [5] = '{10'd1, 10'd1023, 10'd0, 10'd1000, 10'd168};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [MHZ_W-1:0]      cfg_wr_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// predictor state
	logic [MHZ_W-1:0]  mhz_setting;
	logic [CYC_W-1:0]  prev_sample;
	logic [WRAP_W-1:0] wrap_tally;

	stamp_t stamp_q [$];
	stamp_t got_stamp;
	stamp_t want_stamp;
	int     mismatches = 0;
	bit     steady = 1'b0;

	cycle_count_timebase dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// wrap extension and time split for one sample
	function automatic stamp_t advance_timebase(logic [CYC_W-1:0] sample, logic restart);
		logic [63:0] now_ext;
		logic [63:0] total;
		logic [63:0] mhz;
		logic [63:0] hz;
		logic [63:0] per_ms;
		logic [63:0] rem;
		logic [63:0] rem2;
		stamp_t s;
		now_ext = 64'(sample) & ((64'd1 << COUNT_BITS) - 64'd1);
		if (restart) begin
			wrap_tally = '0;
		end else if (CYC_W'(now_ext) < prev_sample) begin
			wrap_tally = wrap_tally + 1'b1;
		end
		prev_sample = CYC_W'(now_ext);
		total = (64'(wrap_tally) << COUNT_BITS) + now_ext;
		// a clock of zero counts as 1 MHz
		mhz = (mhz_setting == '0) ? 64'd1 : 64'(mhz_setting);
		hz = mhz * 64'(PER_SECOND);
		per_ms = mhz * 64'(PER_MILLI);
		rem = total % hz;
		rem2 = rem % per_ms;
		s.total = total;
		s.secs = SEC_W'(total / hz);
		s.msec = FRAC_W'(rem / per_ms);
		s.usec = FRAC_W'(rem2 / mhz);
		s.micros = total / mhz;
		return s;
	endfunction

	// register write, only once every pending result has come back
	task automatic write_mhz(logic [MHZ_W-1:0] value);
		s_axis_tvalid = 1'b0;
		while (stamp_q.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		mhz_setting = value;
	endtask

	// one input beat, with a random gap ahead of it unless steady is set
	task automatic send_sample(logic [CYC_W-1:0] sample, logic restart, output stamp_t pred);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = sample;
		s_axis_tuser = restart;
		do @(posedge clk); while (!s_axis_tready);
		pred = advance_timebase(sample, restart);
		@(negedge clk);
	endtask

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// stimulus
	initial begin
		stamp_t pred;
		logic [MHZ_W-1:0] pick;
		logic [CYC_W-1:0] cursor;
		logic restart;
		int phase;
		int run_len;
		int samples_sent;
		int r;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		mhz_setting = CPU_MHZ_RESET;
		prev_sample = '0;
		wrap_tally = '0;
		phase = 0;
		samples_sent = 0;
		cursor = $urandom();
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < DIR_ROWS_N; i++) begin
			if (DIR_ROWS[i].kind == ROW_CFG) begin
				write_mhz(DIR_ROWS[i].mhz);
			end else begin
				send_sample(DIR_ROWS[i].sample, DIR_ROWS[i].restart, pred);
				if (DIR_ROWS[i].kind == ROW_TYPED)
					stamp_q.push_back(DIR_ROWS[i].want);
				else
					stamp_q.push_back(pred);
			end
		end

		// random phases, each under one clock setting
		while (samples_sent < RANDOM_ITEMS) begin
			if (phase < 5) begin
				pick = EXTREME_MHZ[phase];
			end else begin
				r = $urandom_range(0, 9);
				if (r < 8)
					pick = MHZ_W'($urandom_range(1, 1000));
				else if (r == 8)
					pick = MHZ_W'($urandom_range(1001, 1023));
				else
					pick = '0;
			end
			write_mhz(pick);
			steady = ($urandom_range(0, 3) == 0);
			run_len = $urandom_range(80, 160);
			if (run_len > RANDOM_ITEMS - samples_sent)
				run_len = RANDOM_ITEMS - samples_sent;
			repeat (run_len) begin
				// mostly a running counter, with wraps, repeats and noise mixed in
				r = $urandom_range(0, 99);
				restart = ($urandom_range(0, 99) < 4);
				if (r < 40)
					cursor = cursor + CYC_W'($urandom_range(0, 5000));
				else if (r < 65)
					cursor = cursor + CYC_W'($urandom_range(0, 32'h3FFF_FFFF));
				else if (r < 82)
					cursor = cursor + CYC_W'($urandom());
				else if (r >= 90)
					cursor = CYC_W'($urandom());
				send_sample(cursor, restart, pred);
				stamp_q.push_back(pred);
				samples_sent++;
			end
			phase++;
		end
		steady = 1'b0;

		// drain and report
		s_axis_tvalid = 1'b0;
		while (stamp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("cycle_count_timebase_tb OK");
		else
			$display("cycle_count_timebase_tb NOT OK");
		$finish;
	end

	// receiver with random stalls after the result shows up, unless steady is set
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				do @(posedge clk); while (!m_axis_tvalid);
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// result check against the oldest pending stamp
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_stamp.total = m_axis_tdata[TOTAL_W-1:0];
			got_stamp.secs = m_axis_tdata[SEC_LSB +: SEC_W];
			got_stamp.msec = m_axis_tdata[MS_LSB +: FRAC_W];
			got_stamp.usec = m_axis_tdata[US_LSB +: FRAC_W];
			got_stamp.micros = m_axis_tdata[MICRO_LSB +: TOTAL_W];
			if (stamp_q.size() == 0) begin
				$error("result beat with no sample pending");
				mismatches++;
			end else begin
				want_stamp = stamp_q.pop_front();
				compare_field("total_cycles", want_stamp.total, got_stamp.total);
				compare_field("seconds", 64'(want_stamp.secs), 64'(got_stamp.secs));
				compare_field("milliseconds", 64'(want_stamp.msec), 64'(got_stamp.msec));
				compare_field("microseconds", 64'(want_stamp.usec), 64'(got_stamp.usec));
				compare_field("total_micros", want_stamp.micros, got_stamp.micros);
			end
		end
	end

	// hang guard
	initial begin
		#20_000_000;
		$display("cycle_count_timebase_tb NOT OK");
		$finish;
	end

endmodule
